// ===== rtl/vdit_pkg.sv =====
// shared types, constants and compare helpers for the vertex dedup index table
package vdit_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W     = 64;
  localparam int OUT_IDX_W   = 10;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_NAN  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vert_t;

  function automatic logic is_nan(input logic [COORD_W-1:0] v);
    return (v[62:52] == '1) && (v[51:0] != '0);
  endfunction

  function automatic logic same_coord(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
    return (a == b) || ((a[62:0] == '0) && (b[62:0] == '0));
  endfunction

  function automatic logic same_vert(input vert_t a, input vert_t b);
    return same_coord(a.x, b.x) && same_coord(a.y, b.y) && same_coord(a.z, b.z);
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [CNT_W-1:0] v);
    return OUT_IDX_W'(v);
  endfunction

endpackage

// ===== rtl/vdit_ifs.sv =====
// valid/ready channels for incoming vertices and outgoing index results
interface vdit_in_if;
  logic                          valid;
  logic                          ready;
  logic [vdit_pkg::COORD_W-1:0]  coord_x;
  logic [vdit_pkg::COORD_W-1:0]  coord_y;
  logic [vdit_pkg::COORD_W-1:0]  coord_z;
  logic                          start_mesh;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output start_mesh, input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                input start_mesh, output ready);
endinterface

interface vdit_out_if;
  logic                           valid;
  logic                           ready;
  logic [vdit_pkg::OUT_IDX_W-1:0] merged_index;
  logic                           is_new;
  logic [vdit_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output merged_index, output is_new, output status,
                  input ready);
  modport sink (input valid, input merged_index, input is_new, input status,
                output ready);
endinterface

// ===== rtl/vertex_dedup_index_table.sv =====
// vertex dedup index table: exact duplicate vertex welding over a linear vertex memory
//
// in_ch takes one vertex word (x, y, z as double bit patterns plus start_mesh).
// out_ch gives one result word per vertex: merged_index, is_new and status.
// start_mesh empties the table before the vertex is handled.
// a vertex is searched against the stored unique vertices in order of first
// appearance, one memory read issued per cycle; each compare works on the registered read data.
// a NaN vertex goes from idle straight to done; any other vertex is searched
// until a hit or a miss, and each result is then loaded into the output register.
// one vertex is in flight at a time; in_ch is ready only while idle, so the
// sustained rate is set by the search length and by stalls on out_ch.
// a miss appends the vertex to the memory in the cycle the search ends;
// a full table drops it with status 1, a NaN coordinate gives status 2.
// the result sits in an output register; while out_ch stalls, a finished
// vertex waits and no new vertex is taken.
// synchronous reset empties the table and drops any word in flight; the
// memory itself is not cleared.
module vertex_dedup_index_table (
  input logic clk,
  input logic rst,
  vdit_in_if.sink    in_ch,
  vdit_out_if.source out_ch
);
  import vdit_pkg::*;

  vert_t              mem [TABLE_DEPTH];
  vert_t              rd_data;
  vert_t              cur;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   pend_idx;
  logic               pend_valid;
  state_t             state;
  state_t             state_next;

  logic [OUT_IDX_W-1:0] res_index;
  logic                 res_new;
  status_t              res_status;

  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_index;
  logic                 out_new;
  status_t              out_status;

  logic accept;
  logic in_nan;
  logic issue;
  logic hit;
  logic miss;
  logic full;
  logic out_load;

  assign in_nan = is_nan(in_ch.coord_x) || is_nan(in_ch.coord_y) || is_nan(in_ch.coord_z);
  assign hit    = pend_valid && same_vert(cur, rd_data);
  assign full   = (count == CNT_W'(TABLE_DEPTH));

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    miss        = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_SEARCH: begin
        issue = (idx < count) && !hit;
        miss  = !pend_valid && (idx == count);
      end
      ST_DONE: begin
        out_load = !out_valid || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = in_nan ? ST_DONE : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (hit || miss) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (issue) rd_data <= mem[idx[IDX_W-1:0]];
    if (miss && !full) mem[count[IDX_W-1:0]] <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issue;
      if (accept && in_ch.start_mesh) count <= '0;
      else if (miss && !full)         count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur.x <= in_ch.coord_x;
      cur.y <= in_ch.coord_y;
      cur.z <= in_ch.coord_z;
      idx   <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (issue) pend_idx <= idx;
  end

  // result of the current vertex
  always_ff @(posedge clk) begin
    if (accept && in_nan) begin
      res_index  <= '0;
      res_new    <= 1'b0;
      res_status <= STATUS_NAN;
    end else if (hit) begin
      res_index  <= to_out_idx(pend_idx);
      res_new    <= 1'b0;
      res_status <= STATUS_OK;
    end else if (miss) begin
      res_index  <= full ? '0 : to_out_idx(count);
      res_new    <= !full;
      res_status <= full ? STATUS_FULL : STATUS_OK;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index  <= res_index;
      out_new    <= res_new;
      out_status <= res_status;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.merged_index = out_index;
  assign out_ch.is_new       = out_new;
  assign out_ch.status       = out_status;

endmodule

// ===== sim/tb.sv =====
// testbench for the vertex dedup index table: directed, full-table and random mesh tests
module tb;
  import vdit_pkg::*;

  localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_TWO   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] DBL_THREE = 64'h4008_0000_0000_0000;
  localparam logic [63:0] POS_ZERO  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF   = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SIG_NAN   = 64'h7FF0_0000_0000_0001;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX_FIN   = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX   = 64'hFFEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_SUB   = 64'h0000_0000_0000_0001;
  localparam logic [63:0] NEG_SUB   = 64'h8000_0000_0000_0001;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct {
    logic [OUT_IDX_W-1:0] idx;
    logic                 is_new;
    status_t              status;
  } weld_result_t;

  logic clk = 1'b0;
  logic rst;

  vdit_in_if  in_ch ();
  vdit_out_if out_ch ();

  vertex_dedup_index_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  logic [63:0]  weld_x [TABLE_DEPTH];
  logic [63:0]  weld_y [TABLE_DEPTH];
  logic [63:0]  weld_z [TABLE_DEPTH];
  int           weld_count = 0;
  weld_result_t expected_welds [$];
  weld_result_t oldest_weld;
  int           fault_count = 0;
  int           burst_left = 0;
  logic [15:0]  stall_pattern = 16'hFFFF;
  int           stall_tick = 0;

  function automatic logic coord_is_nan(input logic [63:0] c);
    return c[62:0] > POS_INF[62:0];
  endfunction

  function automatic logic coord_match(input logic [63:0] a, input logic [63:0] b);
    return (a == b) || ((a[62:0] == '0) && (b[62:0] == '0));
  endfunction

  function automatic weld_result_t weld_vertex(input logic [63:0] x, input logic [63:0] y,
                                               input logic [63:0] z, input logic start);
    weld_result_t r;
    int hit;
    r.idx = '0;
    r.is_new = 1'b0;
    r.status = STATUS_OK;
    hit = -1;
    if (start) weld_count = 0;
    if (coord_is_nan(x) || coord_is_nan(y) || coord_is_nan(z)) begin
      r.status = STATUS_NAN;
      return r;
    end
    for (int i = 0; i < weld_count; i++) begin
      if (hit < 0 && coord_match(x, weld_x[i]) && coord_match(y, weld_y[i]) &&
          coord_match(z, weld_z[i])) hit = i;
    end
    if (hit >= 0) begin
      r.idx = OUT_IDX_W'(hit);
      return r;
    end
    if (weld_count >= TABLE_DEPTH) begin
      r.status = STATUS_FULL;
      return r;
    end
    weld_x[weld_count] = x;
    weld_y[weld_count] = y;
    weld_z[weld_count] = z;
    r.idx = OUT_IDX_W'(weld_count);
    r.is_new = 1'b1;
    weld_count++;
    return r;
  endfunction

  function automatic logic [63:0] random_coord();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: v = {v[63], 63'd0};
      1: v = {v[63], 11'h7FF, 52'd0};
      2: v = {v[63], 11'h3FF, v[51:50], 50'd0};
      default: if (v[62:52] == 11'h7FF) v[62] = 1'b0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] nan_coord();
    logic [63:0] v;
    v = {$urandom, $urandom};
    v[62:52] = 11'h7FF;
    if (v[51:0] == '0) v[0] = 1'b1;
    return v;
  endfunction

  function automatic logic [63:0] flip_zero_sign(input logic [63:0] c);
    if (c[62:0] == '0 && $urandom_range(0, 1) == 1) c[63] = ~c[63];
    return c;
  endfunction

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_welds.size() == 0) begin
        report_fault($sformatf("unexpected word: idx %0d new %0b status %0d",
                               out_ch.merged_index, out_ch.is_new, out_ch.status));
      end else begin
        oldest_weld = expected_welds.pop_front();
        if (out_ch.merged_index !== oldest_weld.idx || out_ch.is_new !== oldest_weld.is_new ||
            out_ch.status !== oldest_weld.status)
          report_fault({$sformatf("mismatch: expected idx %0d new %0b status %0d",
                                  oldest_weld.idx, oldest_weld.is_new, oldest_weld.status),
                        $sformatf(", got idx %0d new %0b status %0d",
                                  out_ch.merged_index, out_ch.is_new, out_ch.status)});
      end
    end
    out_ch.ready <= stall_pattern[0];
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 63) begin
      if ($urandom_range(0, 3) == 0) stall_pattern <= 16'hFFFF;
      else stall_pattern <= 16'($urandom) | 16'h0101;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  task automatic send_vertex(input logic [63:0] x, input logic [63:0] y,
                             input logic [63:0] z, input logic start);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    in_ch.start_mesh <= start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_welds.insert(expected_welds.size(), weld_vertex(x, y, z, start));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained(input int tail);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_welds.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic test_basic_weld();
    send_vertex(DBL_ONE, DBL_TWO, DBL_THREE, 1'b1);
    send_vertex(DBL_ONE, DBL_TWO, DBL_THREE, 1'b0);
    send_vertex(DBL_TWO, DBL_TWO, DBL_THREE, 1'b0);
    send_vertex(DBL_ONE, DBL_TWO, DBL_THREE, 1'b0);
    send_vertex(POS_ZERO, POS_ZERO, POS_ZERO, 1'b0);
    send_vertex(NEG_ZERO, NEG_ZERO, POS_ZERO, 1'b0);
    send_vertex(NEG_ZERO, POS_ZERO, NEG_ZERO, 1'b0);
  endtask

  task automatic test_special_coords();
    send_vertex(POS_INF, NEG_INF, POS_INF, 1'b0);
    send_vertex(NEG_INF, NEG_INF, POS_INF, 1'b0);
    send_vertex(POS_INF, NEG_INF, POS_INF, 1'b0);
    send_vertex(QUIET_NAN, DBL_ONE, DBL_ONE, 1'b0);
    send_vertex(DBL_ONE, SIG_NAN, DBL_ONE, 1'b0);
    send_vertex(DBL_ONE, DBL_ONE, ALL_ONES, 1'b0);
    send_vertex(MAX_FIN, NEG_MAX, MAX_FIN, 1'b0);
    send_vertex(NEG_MAX, NEG_MAX, MAX_FIN, 1'b0);
    send_vertex(MIN_SUB, POS_ZERO, DBL_ONE, 1'b0);
    send_vertex(NEG_SUB, NEG_ZERO, DBL_ONE, 1'b0);
    // new mesh opened by a dropped NaN word, then an old vertex is new again
    send_vertex(DBL_ONE, 64'h7FFF_FFFF_FFFF_FFFF, DBL_ONE, 1'b1);
    send_vertex(DBL_ONE, DBL_TWO, DBL_THREE, 1'b0);
  endtask

  task automatic test_table_full();
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] fz;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_vertex(random_coord(), random_coord(), {1'b0, 11'h400, 42'd0, 10'(i)}, i == 0);
    fx = weld_x[0];
    fy = weld_y[0];
    fz = weld_z[0];
    send_vertex(fx, fy, fz, 1'b0);
    fx = weld_x[TABLE_DEPTH-1];
    fy = weld_y[TABLE_DEPTH-1];
    fz = weld_z[TABLE_DEPTH-1];
    send_vertex(flip_zero_sign(fx), flip_zero_sign(fy), fz, 1'b0);
    send_vertex(DBL_THREE, DBL_TWO, DBL_ONE, 1'b0);
    send_vertex(DBL_THREE, nan_coord(), DBL_ONE, 1'b0);
    send_vertex(NEG_INF, POS_ZERO, MIN_SUB, 1'b0);
    send_vertex(DBL_THREE, DBL_TWO, DBL_ONE, 1'b1);
  endtask

  task automatic test_random_meshes(input int count);
    vert_t v;
    vert_t mesh_pool [$];
    logic start;
    int pick;
    int slot;
    for (int k = 0; k < count; k++) begin
      start = (k == 0) || ($urandom_range(0, 19) == 0) || (weld_count >= 48);
      if (start) mesh_pool.delete();
      pick = $urandom_range(0, 99);
      if (pick < 45 && mesh_pool.size() != 0) begin
        v = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
        v.x = flip_zero_sign(v.x);
        v.y = flip_zero_sign(v.y);
        v.z = flip_zero_sign(v.z);
      end else if (pick < 93) begin
        v.x = random_coord();
        v.y = random_coord();
        v.z = random_coord();
        // near misses that share coordinates with a stored vertex
        if (mesh_pool.size() != 0 && $urandom_range(0, 2) == 0) begin
          slot = $urandom_range(0, mesh_pool.size() - 1);
          v.x = mesh_pool[slot].x;
          if ($urandom_range(0, 1) == 1) v.y = mesh_pool[slot].y;
        end
        mesh_pool.insert(mesh_pool.size(), v);
      end else begin
        v.x = random_coord();
        v.y = random_coord();
        v.z = random_coord();
        case ($urandom_range(0, 2))
          0: v.x = nan_coord();
          1: v.y = nan_coord();
          default: v.z = nan_coord();
        endcase
      end
      send_vertex(v.x, v.y, v.z, start);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.coord_z <= '0;
    in_ch.start_mesh <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_basic_weld();
    test_special_coords();
    wait_drained($urandom_range(0, 5));
    test_table_full();
    wait_drained($urandom_range(0, 5));
    test_random_meshes(540);
    wait_drained(DRAIN_CYCLES);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
